### rtl/sha256_message_digest_assert.svh
// Assertion macros used by the SHA-256 digest RTL.
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256 assertion failed");

// Next-cycle implication, checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha256 assertion failed");

`endif

### rtl/sha256md_pkg.sv
// Package with SHA-256 constants, helper functions and the core control struct.
`default_nettype none
package sha256md_pkg;

   localparam int unsigned NUM_CHAIN = 8;
   localparam int unsigned NUM_SCHED = 16;

   localparam logic [31:0] SHA_IV [NUM_CHAIN] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   // Control from the sequencer to the round core.
   typedef struct packed {
      logic init;    // reload chaining words with the initial values
      logic step;    // run one round
      logic first;   // first round of a block: take a..h from the chain
      logic fold;    // add a..h into the chaining words
   } core_ctl_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

### rtl/sha256md_round_core.sv
// SHA-256 round unit: working variables, schedule window and chaining words.
`default_nettype none
module sha256md_round_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sha256md_pkg::core_ctl_type ctl,
   input  wire logic [5:0]                 rnd,
   input  wire logic [31:0]                blk_word,
   input  wire logic [2:0]                 out_sel,
   output logic [31:0]                     chain_word
);
   import sha256md_pkg::*;

   logic [31:0] chain_ff [NUM_CHAIN];
   logic [31:0] chain_in [NUM_CHAIN];
   logic [31:0] vars_ff  [NUM_CHAIN];
   logic [31:0] vars_in  [NUM_CHAIN];
   logic [31:0] sched_ff [NUM_SCHED];
   logic [31:0] sched_in [NUM_SCHED];
   logic [31:0] cur      [NUM_CHAIN];
   logic [31:0] w_t;
   logic [31:0] t1;
   logic [31:0] t2;

   always_comb begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
         cur[i] = ctl.first ? chain_ff[i] : vars_ff[i];
      end
      // window: sched_ff[0] is W[t-16], sched_ff[15] is W[t-1]
      if (rnd < 6'd16) begin
         w_t = blk_word;
      end else begin
         w_t = sched_ff[0] + small_sigma0(sched_ff[1]) + sched_ff[9]
             + small_sigma1(sched_ff[14]);
      end
      t1 = cur[7] + big_sigma1(cur[4]) + ((cur[4] & cur[5]) ^ (~cur[4] & cur[6]))
         + SHA_K[rnd] + w_t;
      t2 = big_sigma0(cur[0]) + ((cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]));

      vars_in  = vars_ff;
      sched_in = sched_ff;
      if (ctl.step) begin
         vars_in[7] = cur[6];
         vars_in[6] = cur[5];
         vars_in[5] = cur[4];
         vars_in[4] = cur[3] + t1;
         vars_in[3] = cur[2];
         vars_in[2] = cur[1];
         vars_in[1] = cur[0];
         vars_in[0] = t1 + t2;
         for (int i = 0; i < NUM_SCHED - 1; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[NUM_SCHED - 1] = w_t;
      end

      chain_in = chain_ff;
      if (ctl.init) begin
         chain_in = SHA_IV;
      end else if (ctl.fold) begin
         for (int i = 0; i < NUM_CHAIN; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SHA_IV;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff  <= vars_in;
      sched_ff <= sched_in;
   end

   assign chain_word = chain_ff[out_sel];

endmodule
`default_nettype wire

### rtl/sha256_message_digest.sv
// SHA-256 digest engine, one message byte per input word, eight digest words out.
// A byte is buffered on acceptance; one that fills a block starts 64 rounds, then the fold.
// End of message: one or two more compressions, then 8 output words.
// Bytes are not accepted while the single round unit compresses a block or the digest is output.
// Reset (sync, active high) loads the initial hash values and clears counts;
//   the block buffer and round registers are not cleared.
`default_nettype none
`include "sha256_message_digest_assert.svh"
module sha256_message_digest (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_word_last
);
   import sha256md_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   // what follows the compression that is running
   typedef enum logic [1:0] {
      JOB_NONE,   // back to idle
      JOB_PAD,    // padding block starting at byte 0 (marker + length)
      JOB_LEN,    // all-zero block carrying only the length
      JOB_OUT     // emit the digest
   } job_type;

   localparam logic [6:0] FULL_LIMIT = 7'd64;
   localparam logic [6:0] LEN_LIMIT  = 7'd56;
   localparam logic [6:0] LAST_BYTE  = 7'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   state_type    state_ff, state_in;
   job_type      job_ff, job_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic [6:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [6:0]   lim_ff, lim_in;        // bytes below this come from the buffer
   logic         marker_ff, marker_in;  // 0x80 sits at byte lim
   logic         len_ff, len_in;        // words 14 and 15 carry the bit count
   logic [2:0]   out_idx_ff, out_idx_in;
   logic [31:0]  blk_buf_ff [16];

   logic         acc;
   logic         out_acc;
   logic [6:0]   fill_after;
   logic [31:0]  buf_word;
   logic [31:0]  blk_word;
   logic [6:0]   pos;
   core_ctl_type ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign acc       = req_valid & req_ready;
   assign out_acc   = rsp_valid & rsp_ready;
   assign rsp_word_last = (out_idx_ff == LAST_WORD);
   assign fill_after = req_byte_present ? (fill_ff + 7'd1) : fill_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      rnd_in     = rnd_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      lim_in     = lim_ff;
      marker_in  = marker_ff;
      len_in     = len_ff;
      out_idx_in = out_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               rnd_in = '0;
               if (req_byte_present) begin
                  bits_in = bits_ff + 64'd8;
               end
               if (req_byte_present && (fill_ff == LAST_BYTE)) begin
                  // block full: plain compression, pad afterward if last
                  fill_in   = '0;
                  lim_in    = FULL_LIMIT;
                  marker_in = 1'b0;
                  len_in    = 1'b0;
                  job_in    = req_end_of_message ? JOB_PAD : JOB_NONE;
                  state_in  = ST_ROUND;
               end else if (req_end_of_message) begin
                  fill_in   = '0;
                  lim_in    = fill_after;
                  marker_in = 1'b1;
                  if (fill_after < LEN_LIMIT) begin
                     len_in = 1'b1;
                     job_in = JOB_OUT;
                  end else begin
                     // no room for the length: second block
                     len_in = 1'b0;
                     job_in = JOB_LEN;
                  end
                  state_in = ST_ROUND;
               end else begin
                  fill_in = fill_after;
               end
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            rnd_in = '0;
            case (job_ff)
               JOB_NONE: state_in = ST_IDLE;
               JOB_PAD: begin
                  lim_in    = '0;
                  marker_in = 1'b1;
                  len_in    = 1'b1;
                  job_in    = JOB_OUT;
                  state_in  = ST_ROUND;
               end
               JOB_LEN: begin
                  lim_in    = '0;
                  marker_in = 1'b0;
                  len_in    = 1'b1;
                  job_in    = JOB_OUT;
                  state_in  = ST_ROUND;
               end
               JOB_OUT: begin
                  out_idx_in = '0;
                  state_in   = ST_OUT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (out_acc) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == LAST_WORD) begin
                  bits_in  = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         job_ff     <= JOB_NONE;
         rnd_ff     <= '0;
         fill_ff    <= '0;
         bits_ff    <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         job_ff     <= job_in;
         rnd_ff     <= rnd_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff    <= lim_in;
      marker_ff <= marker_in;
      len_ff    <= len_in;
   end

   // block buffer, big-endian byte lanes: byte 4t lands in bits 31:24 of word t
   always_ff @(posedge clock) begin
      if (acc && req_byte_present) begin
         blk_buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= req_data_byte;
      end
   end

   // message word for rounds 0..15, padding applied on the fly
   always_comb begin
      buf_word = blk_buf_ff[rnd_ff[3:0]];
      blk_word = '0;
      pos      = '0;
      for (int j = 0; j < 4; j++) begin
         pos = {1'b0, rnd_ff[3:0], 2'(j)};
         if (pos < lim_ff) begin
            blk_word[8*(3-j) +: 8] = buf_word[8*(3-j) +: 8];
         end else if (marker_ff && (pos == lim_ff)) begin
            blk_word[8*(3-j) +: 8] = 8'h80;
         end else begin
            blk_word[8*(3-j) +: 8] = 8'h00;
         end
      end
      if (len_ff && (rnd_ff == 6'd14)) begin
         blk_word = bits_ff[63:32];
      end else if (len_ff && (rnd_ff == 6'd15)) begin
         blk_word = bits_ff[31:0];
      end
   end

   always_comb begin
      ctl.init  = out_acc && (out_idx_ff == LAST_WORD);
      ctl.step  = (state_ff == ST_ROUND);
      ctl.first = (rnd_ff == '0);
      ctl.fold  = (state_ff == ST_FOLD);
   end

   sha256md_round_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rnd        (rnd_ff),
      .blk_word   (blk_word),
      .out_sel    (out_idx_ff),
      .chain_word (rsp_digest_word)
   );

   `SHA_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `SHA_ASSERT_NEXT(a_round_to_fold, clock, reset,
      (state_ff == ST_ROUND) && (rnd_ff == LAST_ROUND), state_ff == ST_FOLD)
   `SHA_ASSERT_NEXT(a_last_word_frees, clock, reset,
      rsp_valid && rsp_ready && rsp_word_last, req_ready && (fill_ff == '0))
   `SHA_ASSERT_NOW(a_fill_in_range, clock, reset, req_ready, fill_ff <= LAST_BYTE)

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the byte-serial SHA-256 digest engine.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any handshake before the run is declared hung.
   // The slowest legal gap is two compressions plus output.
   // Random stalls add to that, so the margin is wide.
   localparam int WATCHDOG_LIMIT = 2000;
   // Settle time after the last digest: covers a two-block pad.
   localparam int DRAIN_CYCLES = 200;
   localparam int IDLE_PCT = 26;
   // Input word budget: the queue is filled until it holds at least this many words.
   localparam int TOTAL_WORDS = 470;

   // Initial hash values, word 0 in the top bits.
   localparam logic [255:0] HASH_IV = {
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   // Round constants, round 0 in the top bits.
   localparam logic [64*32-1:0] ROUND_K = {
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   // One input word as queued for the driver.
   // hold: do not present it until every digest word has come back.
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       eom;
      logic       hold;
   } msg_word_type;

   typedef struct packed {
      logic [31:0] word;
      logic        is_last;
   } digest_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic        rsp_word_last;

   // Stimulus and scoreboard.
   msg_word_type    msg_fifo [$];
   digest_word_type expected_digest [$];
   digest_word_type head_word;
   msg_word_type    next_word;
   int              n_total;
   int              n_accepted;
   int              mismatches;
   int              stall_cycles;
   logic            hold_wait;
   logic            gap_roll;

   // Predictor state: chaining words, bit count, block buffer and fill.
   logic [31:0] hash_state [8];
   logic [63:0] bit_total;
   logic [7:0]  blk_bytes [64];
   int          blk_fill;

   // No idling on either side for a stretch in the middle of the run.
   wire no_idle = (n_accepted >= 200) && (n_accepted < 330);

   sha256_message_digest uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_last      (rsp_word_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [31:0] rot_r(input logic [31:0] x, input int n);
      logic [63:0] dbl;
      dbl = {x, x} >> n;
      return dbl[31:0];
   endfunction

   function automatic void restart_hash();
      int i;
      for (i = 0; i < 8; i++)
         hash_state[i] = HASH_IV[(7 - i) * 32 +: 32];
      bit_total = 64'd0;
      blk_fill = 0;
   endfunction

   // 64-round compression of blk_bytes into hash_state.
   function automatic void absorb_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      int t;
      for (t = 0; t < 16; t++)
         w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
      for (t = 16; t < 64; t++) begin
         s0 = rot_r(w[t-15], 7) ^ rot_r(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rot_r(w[t-2], 17) ^ rot_r(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (t = 0; t < 64; t++) begin
         t1 = h + (rot_r(e, 6) ^ rot_r(e, 11) ^ rot_r(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_K[(63 - t) * 32 +: 32] + w[t];
         t2 = (rot_r(a, 2) ^ rot_r(a, 13) ^ rot_r(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endfunction

   // Apply one accepted word; an end word queues the eight digest words.
   function automatic void hash_word_in(input logic [7:0] data, input logic present,
                                        input logic eom);
      int k;
      if (present) begin
         blk_bytes[blk_fill] = data;
         blk_fill++;
         bit_total += 64'd8;
         if (blk_fill == 64) begin
            absorb_block();
            blk_fill = 0;
         end
      end
      if (eom) begin
         blk_bytes[blk_fill] = 8'h80;
         blk_fill++;
         // No room for the length: pad out and spend an extra block.
         if (blk_fill > 56) begin
            while (blk_fill < 64) begin
               blk_bytes[blk_fill] = 8'h00;
               blk_fill++;
            end
            absorb_block();
            blk_fill = 0;
         end
         while (blk_fill < 56) begin
            blk_bytes[blk_fill] = 8'h00;
            blk_fill++;
         end
         for (k = 0; k < 8; k++)
            blk_bytes[63 - k] = bit_total[8*k +: 8];
         absorb_block();
         for (k = 0; k < 8; k++)
            expected_digest.push_back('{word: hash_state[k], is_last: (k == 7)});
         restart_hash();
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic push_word(input logic [7:0] data, input logic present, input logic eom,
                            input logic hold);
      msg_fifo.push_back('{data: data, present: present, eom: eom, hold: hold});
   endtask

   // A message of nbytes random bytes, with some ignored words mixed in.
   // The end flag rides on the last byte or on a separate byteless word.
   task automatic add_message(input int nbytes, input logic hold);
      int i;
      logic end_on_byte;
      logic first_hold;
      end_on_byte = (nbytes > 0) && ($urandom_range(1) == 1);
      first_hold = hold;
      for (i = 0; i < nbytes; i++) begin
         if ($urandom_range(99) < 10) begin
            push_word(8'($urandom_range(255)), 1'b0, 1'b0, first_hold);
            first_hold = 1'b0;
         end
         push_word(8'($urandom_range(255)), 1'b1, end_on_byte && (i == nbytes - 1),
                   first_hold);
         first_hold = 1'b0;
      end
      if (!end_on_byte)
         push_word(8'($urandom_range(255)), 1'b0, 1'b1, first_hold);
   endtask

   // Mostly short messages, a good share near the padding boundaries.
   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return $urandom_range(10);
      else if (r < 70)
         return $urandom_range(70, 50);
      else if (r < 88)
         return $urandom_range(49, 11);
      return $urandom_range(140, 71);
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents queued words, predicts on each accepted word.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            hash_word_in(req_data_byte, req_byte_present, req_end_of_message);
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            // A digest word taken this same edge still counts as outstanding,
            // so the decision does not hinge on which block runs first.
            hold_wait = (msg_fifo.size() != 0) && msg_fifo[0].hold &&
                        ((expected_digest.size() != 0) || (rsp_valid && rsp_ready));
            gap_roll = !no_idle && ($urandom_range(99) < IDLE_PCT);
            if ((msg_fifo.size() != 0) && !hold_wait && !gap_roll) begin
               next_word = msg_fifo.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_word.data;
               req_byte_present <= next_word.present;
               req_end_of_message <= next_word.eom;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random back-pressure, in-order compare of digest words.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digest.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected digest word: word=%h last=%b",
                           rsp_digest_word, rsp_word_last);
            end else begin
               head_word = expected_digest.pop_front();
               if (rsp_digest_word !== head_word.word ||
                   rsp_word_last !== head_word.is_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("digest mismatch: expected word=%h last=%b, got word=%h last=%b",
                              head_word.word, head_word.is_last,
                              rsp_digest_word, rsp_word_last);
               end
            end
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: any handshake restarts the count.
   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int len;
      int forced_len [4];
      int m;
      forced_len = '{55, 56, 63, 64};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_byte_present = 1'b0;
      req_end_of_message = 1'b0;
      rsp_ready = 1'b0;
      n_accepted = 0;
      mismatches = 0;
      restart_hash();

      // Directed: empty message (end word with no byte).
      push_word(8'h3C, 1'b0, 1'b1, 1'b0);
      // "abc", last byte carries the end flag.
      push_word(8'h61, 1'b1, 1'b0, 1'b0);
      push_word(8'h62, 1'b1, 1'b0, 1'b0);
      push_word(8'h63, 1'b1, 1'b1, 1'b0);
      // Byte extremes, ignored words with both data extremes, end without byte.
      push_word(8'h00, 1'b1, 1'b0, 1'b0);
      push_word(8'hFF, 1'b0, 1'b0, 1'b0);
      push_word(8'hFF, 1'b1, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b0, 1'b0);
      push_word(8'hA5, 1'b0, 1'b1, 1'b0);
      // Single-byte message, sent only once the pipe has drained.
      push_word(8'hFF, 1'b1, 1'b1, 1'b1);

      // Random: first the padding boundaries, then random lengths,
      // trimmed so the run stays near the word budget.
      m = 0;
      while (msg_fifo.size() < TOTAL_WORDS) begin
         len = (m < 4) ? forced_len[m] : pick_length();
         if (len > TOTAL_WORDS - msg_fifo.size())
            len = TOTAL_WORDS - msg_fifo.size();
         add_message(len, (m == 0) || ($urandom_range(7) == 0));
         m++;
      end
      n_total = msg_fifo.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // All words in, all digests back; a word taken this edge is outstanding.
      do
         @(posedge clock);
      while (n_accepted != n_total || expected_digest.size() != 0 ||
             (rsp_valid && rsp_ready));
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_digest.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/sha256md_pkg.sv
rtl/sha256md_round_core.sv
rtl/sha256_message_digest.sv
bench/tb_top.sv
